// ===== hdl/rcw_pkg.sv =====
// shared types, constants and helper functions of the rainbow color wheel
`default_nettype none

package rcw_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int LEN_W         = 16;
  localparam int CH_W          = 8;
  localparam int PROD_W        = LEN_W + CH_W;
  localparam int SEG_W         = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);
  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
  localparam logic [CH_W-1:0]  CH_FULL   = {CH_W{1'b1}};
  localparam logic [CH_W-1:0]  CH_OFF    = '0;

  typedef logic [SEG_W-1:0] seg_t;

  // segment codes, named by the channel that moves
  localparam seg_t SEG_GREEN_UP   = 3'd0;
  localparam seg_t SEG_RED_DOWN   = 3'd1;
  localparam seg_t SEG_BLUE_UP    = 3'd2;
  localparam seg_t SEG_GREEN_DOWN = 3'd3;
  localparam seg_t SEG_RED_UP     = 3'd4;
  localparam seg_t SEG_BLUE_DOWN  = 3'd5;
  localparam logic [SEG_W:0] SEG_COUNT = 4'd6;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // quotient mod 6 after appending one more quotient bit
  function automatic seg_t seg_advance(input seg_t seg, input logic qbit);
    logic [SEG_W:0] t;
    t = {seg, qbit};
    if (t >= SEG_COUNT) begin
      t = t - SEG_COUNT;
    end
    return t[SEG_W-1:0];
  endfunction

  function automatic rgb_t wheel_color(input seg_t seg, input logic [CH_W-1:0] ramp);
    rgb_t c;
    case (seg)
      SEG_GREEN_UP:   c = '{red: CH_FULL,         green: ramp,            blue: CH_OFF};
      SEG_RED_DOWN:   c = '{red: CH_FULL - ramp,  green: CH_FULL,         blue: CH_OFF};
      SEG_BLUE_UP:    c = '{red: CH_OFF,          green: CH_FULL,         blue: ramp};
      SEG_GREEN_DOWN: c = '{red: CH_OFF,          green: CH_FULL - ramp,  blue: CH_FULL};
      SEG_RED_UP:     c = '{red: ramp,            green: CH_OFF,          blue: CH_FULL};
      SEG_BLUE_DOWN:  c = '{red: CH_FULL,         green: CH_OFF,          blue: CH_FULL - ramp};
      default:        c = '{red: CH_FULL,         green: CH_OFF,          blue: CH_OFF};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rcw_div_cell.sv =====
// one restoring-division cell: one quotient bit per cell, registered
`default_nettype none

module rcw_div_cell
  import rcw_pkg::*;
#(
  parameter int SHIFT_W = 16,
  parameter bit MOD_EN  = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [LEN_W-1:0]   len,
  input  wire logic               in_vld,
  input  wire logic [LEN_W-1:0]   in_rem,
  input  wire logic [SHIFT_W-1:0] in_word,
  input  wire seg_t               in_seg,
  output logic                    out_vld,
  output logic [LEN_W-1:0]        out_rem,
  output logic [SHIFT_W-1:0]      out_word,
  output seg_t                    out_seg
);

  logic               vld_r;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [SHIFT_W-1:0] word_r, word_nxt;
  seg_t               seg_r, seg_nxt;
  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     diff;
  logic               ge;

  always_comb begin
    trial    = {in_rem, in_word[SHIFT_W-1]};
    diff     = trial - {1'b0, len};
    ge       = (trial >= {1'b0, len});
    rem_nxt  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    word_nxt = {in_word[SHIFT_W-2:0], ge};
    seg_nxt  = MOD_EN ? seg_advance(in_seg, ge) : in_seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    seg_r  <= seg_nxt;
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_word = word_r;
  assign out_seg  = seg_r;

endmodule

`default_nettype wire

// ===== hdl/rainbow_color_wheel.sv =====
// start to out_valid: chain a, product register, chain b, output register
// throughput: one transaction per cycle, busy is never raised
// the two chains are built of division cells, one quotient bit per cell
// reset: synchronous active-low rst_n clears all valid flags, interval length to 256
// results are strobed for one cycle on out_valid; the receiver cannot stall
`default_nettype none

module rainbow_color_wheel
  import rcw_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [LEN_W-1:0]     cfg_wdata,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [POS_WIDTH-1:0] in_pos,
  output logic                      out_valid,
  output logic [CH_W-1:0]           out_red,
  output logic [CH_W-1:0]           out_green,
  output logic [CH_W-1:0]           out_blue
);

  localparam int LAT = POS_WIDTH + CH_W + 2;

  // interval length, stored with zero already mapped to one
  logic [LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_we) begin
      len_r <= (cfg_wdata == '0) ? LEN_ONE : cfg_wdata;
    end
  end

  // fully pipelined, so a new transaction is always welcome
  assign busy = 1'b0;

  // chain a: pos / len, remainder left in rem, quotient tracked mod 6 as segment
  logic [POS_WIDTH:0] a_vld;
  logic [LEN_W-1:0]   a_rem  [POS_WIDTH+1];
  logic [POS_WIDTH-1:0] a_word [POS_WIDTH+1];
  seg_t               a_seg  [POS_WIDTH+1];

  assign a_vld[0]  = start && !busy;
  assign a_rem[0]  = '0;
  assign a_word[0] = in_pos;
  assign a_seg[0]  = SEG_GREEN_UP;

  for (genvar i = 0; i < POS_WIDTH; i++) begin : g_chain_a
    rcw_div_cell #(
      .SHIFT_W (POS_WIDTH),
      .MOD_EN  (1'b1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .len      (len_r),
      .in_vld   (a_vld[i]),
      .in_rem   (a_rem[i]),
      .in_word  (a_word[i]),
      .in_seg   (a_seg[i]),
      .out_vld  (a_vld[i+1]),
      .out_rem  (a_rem[i+1]),
      .out_word (a_word[i+1]),
      .out_seg  (a_seg[i+1])
    );
  end

  // rem * 255 as (rem << 8) - rem, one register stage
  logic              m_vld_r;
  logic [PROD_W-1:0] m_prod_r, m_prod_nxt;
  seg_t              m_seg_r;

  assign m_prod_nxt = {a_rem[POS_WIDTH], CH_OFF} - {{CH_W{1'b0}}, a_rem[POS_WIDTH]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= a_vld[POS_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    m_prod_r <= m_prod_nxt;
    m_seg_r  <= a_seg[POS_WIDTH];
  end

  // chain b: prod / len, quotient below 256 since rem < len, so the upper
  // part of prod is already a valid partial remainder and only 8 cells remain
  logic [CH_W:0]    b_vld;
  logic [LEN_W-1:0] b_rem  [CH_W+1];
  logic [CH_W-1:0]  b_word [CH_W+1];
  seg_t             b_seg  [CH_W+1];

  assign b_vld[0]  = m_vld_r;
  assign b_rem[0]  = m_prod_r[PROD_W-1:CH_W];
  assign b_word[0] = m_prod_r[CH_W-1:0];
  assign b_seg[0]  = m_seg_r;

  for (genvar j = 0; j < CH_W; j++) begin : g_chain_b
    rcw_div_cell #(
      .SHIFT_W (CH_W),
      .MOD_EN  (1'b0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .len      (len_r),
      .in_vld   (b_vld[j]),
      .in_rem   (b_rem[j]),
      .in_word  (b_word[j]),
      .in_seg   (b_seg[j]),
      .out_vld  (b_vld[j+1]),
      .out_rem  (b_rem[j+1]),
      .out_word (b_word[j+1]),
      .out_seg  (b_seg[j+1])
    );
  end

  // segment lookup and output register
  logic out_valid_r;
  rgb_t rgb_r, rgb_nxt;

  assign rgb_nxt = wheel_color(b_seg[CH_W], b_word[CH_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_vld[CH_W];
    end
  end

  always_ff @(posedge clk) begin
    rgb_r <= rgb_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = rgb_r.red;
  assign out_green = rgb_r.green;
  assign out_blue  = rgb_r.blue;

  // every result traces back to an accepted transaction
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  // second chain must start from a partial remainder below the divisor
  a_ramp_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld[0] |-> (b_rem[0] < len_r))
    else $error("ramp division entered with remainder out of range");

  // every wheel color has one channel full and one channel off
  a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_red == CH_FULL || out_green == CH_FULL || out_blue == CH_FULL) &&
                   (out_red == CH_OFF || out_green == CH_OFF || out_blue == CH_OFF)))
    else $error("color outside the wheel");

endmodule

`default_nettype wire
